// ----- src/lsc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lsc_pkg
// Shared types, key masks, register indexes and the light phase table for
// the light sequence controller.
// ---------------------------------------------------------------------------
package lsc_pkg;

  localparam logic [15:0] START_KEY_MASK = 16'h8000;
  localparam logic [15:0] STOP_KEY_MASK  = 16'h0008;

  localparam logic [3:0] LAST_PHASE   = 4'd13;
  localparam logic [3:0] LONG_PHASE_A = 4'd6;
  localparam logic [3:0] LONG_PHASE_B = 4'd7;

  localparam logic [15:0] SHORT_TICKS_RESET = 16'd153;
  localparam logic [15:0] LONG_TICKS_RESET  = 16'd3003;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT_TICKS = 2'd0;
  localparam logic [1:0] CFG_LONG_TICKS  = 2'd1;

  typedef struct packed {
    logic start;
    logic stop;
  } keys_t;

  typedef struct packed {
    logic [14:0] port_a_drive;
    logic [2:0]  port_b_drive;
    logic        is_running;
    logic [3:0]  phase_now;
  } result_t;

  function automatic logic [14:0] drive_a(input logic [3:0] phase);
    logic [14:0] value;
    case (phase)
      4'd0, 4'd2, 4'd4:          value = 15'h6000;
      4'd1, 4'd3, 4'd5:          value = 15'h2000;
      4'd6:                      value = 15'h5000;
      4'd7:                      value = 15'h1000;
      4'd8, 4'd10, 4'd12:        value = 15'h2000;
      default:                   value = 15'h0000;
    endcase
    return value;
  endfunction

  function automatic logic [2:0] drive_b(input logic [3:0] phase);
    logic [2:0] value;
    case (phase)
      4'd0, 4'd2, 4'd4:                           value = 3'd4;
      4'd7:                                       value = 3'd1;
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13:     value = 3'd2;
      default:                                    value = 3'd0;
    endcase
    return value;
  endfunction

endpackage
`default_nettype wire

// ----- src/lsc_key_filter.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lsc_key_filter
// Debounce check: a key is pressed when both samples of its port agree and
// the key bit is set.
// ---------------------------------------------------------------------------
module lsc_key_filter (
  input  wire logic [15:0]   port_a_first,
  input  wire logic [15:0]   port_a_second,
  input  wire logic [15:0]   port_b_first,
  input  wire logic [15:0]   port_b_second,
  output lsc_pkg::keys_t     keys
);

  assign keys.start = (port_a_first == port_a_second) &&
                      ((port_a_first & lsc_pkg::START_KEY_MASK) != 16'h0000);
  assign keys.stop  = (port_b_first == port_b_second) &&
                      ((port_b_first & lsc_pkg::STOP_KEY_MASK) != 16'h0000);

endmodule
`default_nettype wire

// ----- src/lsc_sequencer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lsc_sequencer
// Phase state, tick counter and phase length registers; produces one
// result per step from the registered keys.
// ---------------------------------------------------------------------------
module lsc_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            step,
  input  wire lsc_pkg::keys_t  keys,
  output lsc_pkg::result_t     result
);

  logic [15:0] short_ticks;
  logic [15:0] long_ticks;
  logic        running;
  logic [3:0]  phase;
  logic [15:0] ticks;

  logic        running_next;
  logic [3:0]  phase_next;
  logic [15:0] ticks_next;
  logic [16:0] ticks_inc;
  logic [15:0] phase_len;
  logic        phase_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= lsc_pkg::SHORT_TICKS_RESET;
      long_ticks  <= lsc_pkg::LONG_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lsc_pkg::CFG_SHORT_TICKS: short_ticks <= cfg_data;
        lsc_pkg::CFG_LONG_TICKS:  long_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero length behaves as one since the incremented count is never below it
  assign phase_len  = ((phase == lsc_pkg::LONG_PHASE_A) || (phase == lsc_pkg::LONG_PHASE_B))
                      ? long_ticks : short_ticks;
  assign ticks_inc  = {1'b0, ticks} + 17'd1;
  assign phase_done = ticks_inc >= {1'b0, phase_len};

  always_comb begin
    running_next = running;
    phase_next   = phase;
    ticks_next   = ticks;
    result       = '0;
    if (!running) begin
      if (keys.start) begin
        running_next        = 1'b1;
        phase_next          = 4'd0;
        ticks_next          = 16'd0;
        result.port_a_drive = lsc_pkg::drive_a(4'd0);
        result.port_b_drive = lsc_pkg::drive_b(4'd0);
        result.is_running   = 1'b1;
        result.phase_now    = 4'd0;
      end
    end else if (keys.stop) begin
      running_next = 1'b0;
      phase_next   = 4'd0;
      ticks_next   = 16'd0;
    end else begin
      result.port_a_drive = lsc_pkg::drive_a(phase);
      result.port_b_drive = lsc_pkg::drive_b(phase);
      result.is_running   = 1'b1;
      result.phase_now    = phase;
      if (phase_done) begin
        ticks_next = 16'd0;
        phase_next = (phase == lsc_pkg::LAST_PHASE) ? 4'd0 : phase + 4'd1;
      end else begin
        ticks_next = ticks_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= 4'd0;
      ticks   <= 16'd0;
    end else if (step) begin
      running <= running_next;
      phase   <= phase_next;
      ticks   <= ticks_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/lsc_out_reg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lsc_out_reg
// Result register: holds one word until the downstream side takes it.
// ---------------------------------------------------------------------------
module lsc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire lsc_pkg::result_t result_in,
  input  wire logic             take,
  output logic                  valid,
  output lsc_pkg::result_t      result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule
`default_nettype wire

// ----- src/light_sequence_controller.sv -----
`default_nettype none
// path: a word waits in the input register, then its result moves to the result register
// throughput: one word per cycle unless stalled, set by the input to result register pass
// the phase counter and tick counter update in the same pass, so items never wait on state
// reset: idle, phase 0, short length 153 and long length 3003 ticks
// no clearing pass; the block takes words from the first cycle after reset
// ---------------------------------------------------------------------------
// light_sequence_controller
// Scan-tick light sequencer: debounced start and stop keys drive a repeating
// 14-phase light pattern on two ports.
// ---------------------------------------------------------------------------
module light_sequence_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [15:0] port_a_first,
  input  wire logic [15:0] port_a_second,
  input  wire logic [15:0] port_b_first,
  input  wire logic [15:0] port_b_second,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [14:0]      port_a_drive,
  output logic [2:0]       port_b_drive,
  output logic             is_running,
  output logic [3:0]       phase_now
);

  lsc_pkg::keys_t   keys;
  lsc_pkg::keys_t   keys_reg;
  logic             keys_valid;
  logic             advance;
  lsc_pkg::result_t step_result;
  lsc_pkg::result_t out_result;

  lsc_key_filter u_key_filter (
    .port_a_first  (port_a_first),
    .port_a_second (port_a_second),
    .port_b_first  (port_b_first),
    .port_b_second (port_b_second),
    .keys          (keys)
  );

  // input stage moves on whenever the result register is free or being taken
  assign advance    = keys_valid && (!result_valid || !result_stall);
  assign item_stall = keys_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      keys_valid <= 1'b1;
    end else if (advance) begin
      keys_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      keys_reg <= keys;
    end
  end

  lsc_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .keys      (keys_reg),
    .result    (step_result)
  );

  lsc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (step_result),
    .take       (!result_stall),
    .valid      (result_valid),
    .result_out (out_result)
  );

  assign port_a_drive = out_result.port_a_drive;
  assign port_b_drive = out_result.port_b_drive;
  assign is_running   = out_result.is_running;
  assign phase_now    = out_result.phase_now;

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (phase_now <= lsc_pkg::LAST_PHASE))
    else $error("phase index out of range");

  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_running) |->
      (port_a_drive == 15'h0000 && port_b_drive == 3'd0 && phase_now == 4'd0))
    else $error("idle word carries a light pattern");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall && keys_valid))
    else $error("input stalled without a blocked result");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("stepped word did not reach the result register");

endmodule
`default_nettype wire

// ----- dv/light_sequence_controller_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// light_sequence_controller_tb
// Drives scan ticks with debounced start and stop keys into the light
// sequencer, predicts the light pattern and phase of every tick, and checks
// each result word field by field. A short directed pass runs at the reset
// phase lengths. Random legs follow at several phase lengths, with random
// gaps and stalls on both sides after the first leg and one long hold-off on the result side.
// ---------------------------------------------------------------------------
module light_sequence_controller_tb;

  localparam int HANG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int LEG_COUNT = 6;
  localparam int LEG_TICKS = 130;
  localparam int OPENING_ROWS = 13;

  // indexes past the register list, writes there must be ignored
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [15:0] a_first;
    logic [15:0] a_second;
    logic [15:0] b_first;
    logic [15:0] b_second;
  } tick_t;

  typedef struct packed {
    tick_t            tick;
    logic             typed;
    lsc_pkg::result_t want;
  } row_t;

  localparam lsc_pkg::result_t IDLE_LIGHTS   = '0;
  localparam lsc_pkg::result_t PHASE0_LIGHTS = {15'h6000, 3'd4, 1'b1, 4'd0};

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic [15:0] port_a_first;
  logic [15:0] port_a_second;
  logic [15:0] port_b_first;
  logic [15:0] port_b_second;
  logic        result_valid;
  logic        result_stall;
  logic [14:0] port_a_drive;
  logic [2:0]  port_b_drive;
  logic        is_running;
  logic [3:0]  phase_now;

  light_sequence_controller dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .port_a_first (port_a_first),
    .port_a_second(port_a_second),
    .port_b_first (port_b_first),
    .port_b_second(port_b_second),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .port_a_drive (port_a_drive),
    .port_b_drive (port_b_drive),
    .is_running   (is_running),
    .phase_now    (phase_now)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sequencer model state
  logic        seq_running;
  logic [3:0]  seq_phase;
  logic [16:0] seq_ticks;
  logic [15:0] short_len;
  logic [15:0] long_len;

  lsc_pkg::result_t lights_due[$];
  lsc_pkg::result_t seen_word;
  row_t    opening[OPENING_ROWS];
  int      mismatches;
  int      gap_pct;
  int      idle_cycles;
  bit      hold_request;

  function automatic bit key_down(input logic [15:0] first, input logic [15:0] second,
                                  input logic [15:0] mask);
    return (first == second) && ((first & mask) != 16'h0000);
  endfunction

  function automatic lsc_pkg::result_t lights_for(input logic [3:0] phase);
    lsc_pkg::result_t r;
    r.is_running = 1'b1;
    r.phase_now  = phase;
    case (phase)
      4'd0, 4'd2, 4'd4: begin
        r.port_a_drive = 15'h6000;
        r.port_b_drive = 3'd4;
      end
      4'd1, 4'd3, 4'd5: begin
        r.port_a_drive = 15'h2000;
        r.port_b_drive = 3'd0;
      end
      4'd6: begin
        r.port_a_drive = 15'h5000;
        r.port_b_drive = 3'd0;
      end
      4'd7: begin
        r.port_a_drive = 15'h1000;
        r.port_b_drive = 3'd1;
      end
      4'd8, 4'd10, 4'd12: begin
        r.port_a_drive = 15'h2000;
        r.port_b_drive = 3'd2;
      end
      default: begin
        r.port_a_drive = 15'h0000;
        r.port_b_drive = 3'd2;
      end
    endcase
    return r;
  endfunction

  // one scan tick through the sequencer model, returns the light word it shows
  function automatic lsc_pkg::result_t advance_lights(input tick_t t);
    lsc_pkg::result_t r;
    logic [15:0]      len;
    r = IDLE_LIGHTS;
    if (!seq_running) begin
      if (key_down(t.a_first, t.a_second, lsc_pkg::START_KEY_MASK)) begin
        seq_running = 1'b1;
        seq_phase   = 4'd0;
        seq_ticks   = '0;
        r = lights_for(seq_phase);
      end
    end else if (key_down(t.b_first, t.b_second, lsc_pkg::STOP_KEY_MASK)) begin
      seq_running = 1'b0;
      seq_phase   = 4'd0;
      seq_ticks   = '0;
    end else begin
      r = lights_for(seq_phase);
      len = (seq_phase == lsc_pkg::LONG_PHASE_A || seq_phase == lsc_pkg::LONG_PHASE_B)
            ? long_len : short_len;
      seq_ticks = seq_ticks + 17'd1;
      // a zero length falls through here as a length of one
      if (seq_ticks >= {1'b0, len}) begin
        seq_ticks = '0;
        seq_phase = (seq_phase == lsc_pkg::LAST_PHASE) ? 4'd0 : seq_phase + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    t.a_first  = 16'($urandom);
    t.a_second = ($urandom_range(99) < 70) ? t.a_first : 16'($urandom);
    t.b_first  = 16'($urandom);
    t.b_second = t.b_first;
    pick = $urandom_range(99);
    // stop kept rare so the pattern gets through its phases
    if (pick < 3) begin
      t.b_first[3]  = 1'b1;
      t.b_second[3] = 1'b1;
    end else if (pick < 20) begin
      t.b_second = 16'($urandom);
    end else begin
      t.b_first[3]  = 1'b0;
      t.b_second[3] = 1'b0;
    end
    return t;
  endfunction

  task automatic program_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      lsc_pkg::CFG_SHORT_TICKS: short_len = value;
      lsc_pkg::CFG_LONG_TICKS:  long_len = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // offers one word at the falling edge and books its expected lights once taken
  task automatic offer_tick(input tick_t t, input logic typed, input lsc_pkg::result_t want);
    lsc_pkg::result_t lit;
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid    <= 1'b1;
    port_a_first  <= t.a_first;
    port_a_second <= t.a_second;
    port_b_first  <= t.b_first;
    port_b_second <= t.b_second;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    lit = advance_lights(t);
    lights_due.push_back(typed ? want : lit);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (lights_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (lights_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0h", $time,
                 {port_a_drive, port_b_drive, is_running, phase_now});
        mismatches++;
      end else begin
        seen_word = lights_due.pop_front();
        check_field("port_a_drive", seen_word.port_a_drive, port_a_drive);
        check_field("port_b_drive", seen_word.port_b_drive, port_b_drive);
        check_field("is_running", seen_word.is_running, is_running);
        check_field("phase_now", seen_word.phase_now, phase_now);
      end
    end
  end

  // counts cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (rst || cfg_write || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : receiver
    int  hold;
    bit  held;
    held = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          result_stall <= 1'b1;
          @(negedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  initial begin : stimulus
    int          leg;
    int          n;
    logic [15:0] short_set;
    logic [15:0] long_set;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = lsc_pkg::CFG_SHORT_TICKS;
    cfg_data      = 16'h0000;
    item_valid    = 1'b0;
    port_a_first  = 16'h0000;
    port_a_second = 16'h0000;
    port_b_first  = 16'h0000;
    port_b_second = 16'h0000;
    mismatches    = 0;
    idle_cycles   = 0;
    hold_request  = 1'b0;
    gap_pct       = 19;
    seq_running   = 1'b0;
    seq_phase     = 4'd0;
    seq_ticks     = '0;
    short_len     = lsc_pkg::SHORT_TICKS_RESET;
    long_len      = lsc_pkg::LONG_TICKS_RESET;

    // idle ticks, key bounce, port B ignored while idle, port A ignored while running
    opening[0]  = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, IDLE_LIGHTS};
    opening[1]  = {16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1, IDLE_LIGHTS};
    opening[2]  = {16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, IDLE_LIGHTS};
    opening[3]  = {16'h8000, 16'h8000, 16'h0008, 16'h0008, 1'b1, PHASE0_LIGHTS};
    opening[4]  = {16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1, PHASE0_LIGHTS};
    opening[5]  = {16'hFFFF, 16'hFFFF, 16'h0008, 16'h0000, 1'b1, PHASE0_LIGHTS};
    opening[6]  = {16'h0000, 16'h0000, 16'hFFF7, 16'hFFF7, 1'b1, PHASE0_LIGHTS};
    opening[7]  = {16'h0000, 16'h0000, 16'h0008, 16'h0008, 1'b1, IDLE_LIGHTS};
    opening[8]  = {16'h0000, 16'h0000, 16'h0008, 16'h0008, 1'b1, IDLE_LIGHTS};
    opening[9]  = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, PHASE0_LIGHTS};
    opening[10] = {16'h1234, 16'h1234, 16'h0000, 16'h0000, 1'b1, PHASE0_LIGHTS};
    opening[11] = {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, IDLE_LIGHTS};
    opening[12] = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, IDLE_LIGHTS};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (n = 0; n < OPENING_ROWS; n++)
      offer_tick(opening[n].tick, opening[n].typed, opening[n].want);

    for (leg = 0; leg < LEG_COUNT; leg++) begin
      drain();
      case (leg)
        0: begin
          short_set = 16'd1;
          long_set  = 16'd1;
        end
        1: begin
          short_set = 16'd0;
          long_set  = 16'd0;
        end
        2: begin
          short_set = 16'd3;
          long_set  = 16'd5;
        end
        3: begin
          short_set = 16'hFFFF;
          long_set  = 16'hFFFF;
        end
        4: begin
          short_set = 16'd2;
          long_set  = 16'd1;
        end
        default: begin
          short_set = 16'($urandom_range(1, 8));
          long_set  = 16'($urandom_range(1, 8));
        end
      endcase
      program_reg(lsc_pkg::CFG_SHORT_TICKS, short_set);
      program_reg(lsc_pkg::CFG_LONG_TICKS, long_set);
      if (leg == 4) begin
        program_reg(CFG_SPARE_A, 16'($urandom));
        program_reg(CFG_SPARE_B, 16'hFFFF);
      end
      cfg_write <= 1'b0;
      // first leg runs with no gaps or stalls at all
      gap_pct = (leg == 0) ? 0 : 19;
      if (leg == 3)
        hold_request = 1'b1;
      for (n = 0; n < LEG_TICKS; n++)
        offer_tick(random_tick(), 1'b0, IDLE_LIGHTS);
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
